// ----- hw/rtl/erms_pkg.sv -----
// Shared constants and codes for the epoch reclaim metadata slot.
// No dependencies.
package erms_pkg;

  localparam int unsigned MaxReadersDef = 16;
  localparam int unsigned RingDepthDef  = 32;
  localparam int unsigned Epochs        = 3;

  localparam logic [1:0]  EpochInactive = 2'd3;
  localparam logic [15:0] NoOwner       = 16'hFFFF;

  typedef enum logic [2:0] {
    ModePublish = 3'd0,
    ModeEnter   = 3'd1,
    ModeLeave   = 3'd2,
    ModeSnap    = 3'd3,
    ModeRetire  = 3'd4,
    ModeReclaim = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadRdr   = 3'd1,
    StStale    = 3'd2,
    StFull     = 3'd3,
    StBlocked  = 3'd4,
    StReclaim  = 3'd5
  } status_e;

  localparam logic [0:0] CfgActiveReaders = 1'd0;
  localparam logic [0:0] CfgOwnSlot       = 1'd1;

  // Advance an epoch modulo three.
  function automatic logic [1:0] epoch_next(input logic [1:0] e);
    return (e == 2'd2) ? 2'd0 : e + 2'd1;
  endfunction

endpackage

// ----- hw/rtl/erms_ring_mem.sv -----
// Deferred generation store: one synchronous memory holding three rings.
// Depends on erms_pkg.
module erms_ring_mem import erms_pkg::*; #(
  parameter int unsigned RingDepth = RingDepthDef,
  parameter int unsigned AddrW     = $clog2(Epochs * RingDepth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [15:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [15:0]      rdata_o
);
  localparam int unsigned Depth = Epochs * RingDepth;

  logic [15:0] mem_q [Depth];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hw/rtl/epoch_reclaim_metadata_slot_core.sv -----
// Each mode gives one result word per accepted word, except a successful
// try reclaim, which gives one result per deferred item a cycle (up to
// RING_DEPTH) while the output is not stalled, and then its final word;
// the ring memory read port sets that pace. Throughput: one item at a
// time; a waiting result holds off the next input word.
// Reset: epoch 0, all readers inactive, rings empty, record cleared with no
// owner; no clearing pass, the ring memory is guarded by its fill counts.
module epoch_reclaim_metadata_slot_core import erms_pkg::*; #(
  parameter int unsigned MAX_READERS = MaxReadersDef,
  parameter int unsigned RING_DEPTH  = RingDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  reader_i,
  input  logic [31:0] task_state_i,
  input  logic [15:0] generation_i,
  input  logic        alive_i,
  input  logic [31:0] abort_epoch_i,
  input  logic [15:0] lane_i,
  input  logic [15:0] owner_i,
  input  logic [63:0] trace_seq_i,
  input  logic [15:0] expected_generation_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  epoch_o,
  output logic [31:0] reclaim_slot_o,
  output logic [15:0] reclaim_generation_o,
  output logic        last_o,
  output logic [31:0] snap_task_state_o,
  output logic [15:0] snap_generation_o,
  output logic        snap_alive_o,
  output logic [31:0] snap_abort_epoch_o,
  output logic [15:0] snap_lane_o,
  output logic [15:0] snap_owner_o,
  output logic [63:0] snap_trace_seq_o
);
  localparam int unsigned CntW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned IdxW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned AddrW = $clog2(Epochs * RING_DEPTH);
  localparam int unsigned LimW  = $clog2(MAX_READERS + 1);
  localparam int unsigned RidW  = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;

  typedef enum logic [1:0] {
    StIdle, StExec, StWalk, StOut
  } fsm_e;

  fsm_e               state_q;
  logic [4:0]         act_q;
  logic [31:0]        slot_q;
  logic [1:0]         gep_q;
  logic [1:0]         rdr_q [MAX_READERS];
  logic [CntW-1:0]    cnt_q [Epochs];
  logic [31:0]        rts_q, rce_q;
  logic [15:0]        rgen_q, rlane_q, rown_q;
  logic               ralive_q;
  logic [63:0]        rseq_q;

  // captured word
  logic [2:0]  m_q;
  logic [3:0]  rd_q;
  logic [15:0] exp_q;

  logic [CntW-1:0] walk_q, wcnt_q;
  logic            rvalid_q;

  // output register
  logic        ov_q;
  logic [2:0]  ost_q;
  logic [1:0]  oep_q;
  logic [31:0] oslot_q;
  logic [15:0] ogen_q;
  logic        olast_q;
  logic        osnap_q;

  logic [LimW-1:0] limit;
  logic            rdr_ok;
  logic [1:0]      nxt_ep;
  logic            blocked;
  logic [AddrW-1:0] waddr, raddr;
  logic [CntW-1:0] rd_idx;
  logic            mem_we;
  logic [15:0]     mem_rd;
  logic            out_free;
  logic            ov_load;

  assign limit = (32'(act_q) > MAX_READERS) ? LimW'(MAX_READERS) : LimW'(act_q);
  assign rdr_ok = (32'(rd_q) < 32'(limit)) && (32'(rd_q) < MAX_READERS);
  assign nxt_ep = epoch_next(gep_q);
  assign out_free = !ov_q || !out_stall_i;
  assign ov_load = ((state_q == StWalk) && rvalid_q && out_free) ||
                   ((state_q == StOut) && out_free);

  always_comb begin
    blocked = 1'b0;
    for (int i = 0; i < MAX_READERS; i++) begin
      if ((i < int'(limit)) && (rdr_q[i] == nxt_ep)) blocked = 1'b1;
    end
  end

  // While a read word waits on a stalled output, step back so the memory
  // re-reads the same entry.
  assign rd_idx = (rvalid_q && !out_free) ? walk_q - 1'b1 : walk_q;
  assign waddr  = AddrW'(32'(gep_q) * RING_DEPTH + 32'(cnt_q[gep_q]));
  assign raddr  = AddrW'(32'(nxt_ep) * RING_DEPTH + 32'(IdxW'(rd_idx)));
  assign mem_we = (state_q == StExec) && (m_q == ModeRetire) && ralive_q &&
                  (rgen_q == exp_q) && (cnt_q[gep_q] < CntW'(RING_DEPTH));

  erms_ring_mem #(.RingDepth(RING_DEPTH), .AddrW(AddrW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (exp_q),
    .raddr_i (raddr),
    .rdata_o (mem_rd)
  );

  // hold input while busy or while a result word still waits
  assign in_stall_o = (state_q != StIdle) || (ov_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      act_q    <= 5'd16;
      slot_q   <= '0;
      gep_q    <= '0;
      for (int i = 0; i < MAX_READERS; i++) rdr_q[i] <= EpochInactive;
      for (int i = 0; i < Epochs; i++) cnt_q[i] <= '0;
      rts_q    <= '0;
      rce_q    <= '0;
      rgen_q   <= '0;
      rlane_q  <= '0;
      rown_q   <= NoOwner;
      ralive_q <= 1'b0;
      rseq_q   <= '0;
      ov_q     <= 1'b0;
      rvalid_q <= 1'b0;
      walk_q   <= '0;
      wcnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgActiveReaders) act_q <= cfg_data_i[4:0];
        else slot_q <= cfg_data_i;
      end
      if (ov_load) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i && !in_stall_o) begin
            m_q   <= mode_i;
            rd_q  <= reader_i;
            exp_q <= expected_generation_i;
            if (mode_i == ModePublish) begin
              rts_q    <= task_state_i;
              rgen_q   <= generation_i;
              ralive_q <= alive_i;
              rce_q    <= abort_epoch_i;
              rlane_q  <= lane_i;
              rown_q   <= owner_i;
              rseq_q   <= trace_seq_i;
            end
            state_q <= StExec;
          end
        end
        StExec: begin
          // one result word per item, except a clear reclaim which walks
          oep_q   <= gep_q;
          oslot_q <= '0;
          ogen_q  <= '0;
          olast_q <= 1'b1;
          case (m_q)
            ModeEnter, ModeLeave, ModeSnap: begin
              state_q <= StOut;
              if (!rdr_ok) begin
                ost_q   <= StBadRdr;
                osnap_q <= 1'b0;
              end else begin
                rdr_q[RidW'(rd_q)] <= (m_q == ModeEnter) ? gep_q : EpochInactive;
                ost_q   <= StOk;
                osnap_q <= (m_q == ModeSnap);
              end
            end
            ModeRetire: begin
              state_q <= StOut;
              osnap_q <= 1'b0;
              if (!ralive_q || rgen_q != exp_q) ost_q <= StStale;
              else if (cnt_q[gep_q] >= CntW'(RING_DEPTH)) ost_q <= StFull;
              else begin
                ost_q    <= StOk;
                cnt_q[gep_q] <= cnt_q[gep_q] + 1'b1;
                ralive_q <= 1'b0;
                rown_q   <= NoOwner;
              end
            end
            ModeReclaim: begin
              osnap_q <= 1'b0;
              if (blocked) begin
                ost_q   <= StBlocked;
                state_q <= StOut;
              end else begin
                ost_q    <= StOk;
                walk_q   <= '0;
                wcnt_q   <= cnt_q[nxt_ep];
                rvalid_q <= 1'b0;
                state_q  <= StWalk;
              end
            end
            default: begin
              ost_q   <= StOk;
              osnap_q <= 1'b0;
              state_q <= StOut;
            end
          endcase
        end
        StWalk: begin
          // issue read for walk_q, emit data of the previous read
          if (out_free) begin
            if (rvalid_q) begin
              ost_q   <= StReclaim;
              oep_q   <= gep_q;
              oslot_q <= slot_q;
              ogen_q  <= mem_rd;
              olast_q <= 1'b0;
              osnap_q <= 1'b0;
            end
            if (walk_q < wcnt_q) begin
              walk_q   <= walk_q + 1'b1;
              rvalid_q <= 1'b1;
            end else begin
              rvalid_q <= 1'b0;
              if (!rvalid_q) begin
                cnt_q[nxt_ep] <= '0;
                gep_q   <= nxt_ep;
                ost_q   <= StOk;
                oep_q   <= nxt_ep;
                oslot_q <= '0;
                ogen_q  <= '0;
                olast_q <= 1'b1;
                osnap_q <= 1'b0;
                state_q <= StOut;
              end
            end
          end
        end
        StOut: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o          = ov_q;
  assign status_o             = ost_q;
  assign epoch_o              = oep_q;
  assign reclaim_slot_o       = oslot_q;
  assign reclaim_generation_o = ogen_q;
  assign last_o               = olast_q;
  assign snap_task_state_o    = osnap_q ? rts_q : '0;
  assign snap_generation_o    = osnap_q ? rgen_q : '0;
  assign snap_alive_o         = osnap_q ? ralive_q : 1'b0;
  assign snap_abort_epoch_o   = osnap_q ? rce_q : '0;
  assign snap_lane_o          = osnap_q ? rlane_q : '0;
  assign snap_owner_o         = osnap_q ? rown_q : '0;
  assign snap_trace_seq_o     = osnap_q ? rseq_q : '0;
endmodule

// ----- hw/rtl/erms_checker.sv -----
// Port-level checks for the epoch reclaim slot core, bound to the top level.
// Depends on erms_pkg.
module erms_checker import erms_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [1:0] epoch_o,
  input logic       last_o
);
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("input word dropped while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result word dropped while stalled");

  a_reclaim_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StReclaim |-> !last_o)
    else $error("reclaimed item flagged last");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StReclaim |-> last_o)
    else $error("non-item result not last");

  a_epoch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> epoch_o != EpochInactive)
    else $error("epoch out of range");
endmodule

bind epoch_reclaim_metadata_slot_core erms_checker u_erms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .epoch_o     (epoch_o),
  .last_o      (last_o)
);
